@@ hdl/grim_pkg.sv @@
package grim_pkg;

	// default for the largest supported log2 length
	localparam int unsigned MAX_LOG_LEN_DEF = 16;

	// width of the log_len register
	localparam int unsigned LOG_W = 5;

	// rotation step width
	localparam int unsigned STEP_W = 17;

	// residues are kept modulo 2^17, the largest modulus; smaller ones mask this
	localparam int unsigned RES_W = 17;

	// exponent bits used: the order of 3 modulo 2^17 is 2^15, so 16 bits suffice
	localparam int unsigned EXP_W = 16;
	localparam int unsigned CHUNK_W = 8;
	localparam int unsigned TAB_DEPTH = 1 << CHUNK_W;

	typedef logic [RES_W-1:0] res_t;
	typedef res_t [TAB_DEPTH-1:0] pow_tab_t;

	// stage load enables shared by all pipeline parts
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} pipe_ctrl_t;

	// table of 3^(c * 2^shift) mod 2^17 for every chunk value c; elaboration only
	function automatic pow_tab_t gen_pow_tab(input int unsigned shift);
		pow_tab_t tab;
		logic [2*RES_W-1:0] acc;
		logic [2*RES_W-1:0] base;
		logic [2*RES_W-1:0] mask;
		mask = (2*RES_W)'((64'd1 << RES_W) - 64'd1);
		base = (2*RES_W)'(3);
		for (int unsigned k = 0; k < shift; k++) begin
			base = (base * base) & mask;
		end
		acc = (2*RES_W)'(1);
		for (int unsigned c = 0; c < TAB_DEPTH; c++) begin
			tab[c] = acc[RES_W-1:0];
			acc = (acc * base) & mask;
		end
		return tab;
	endfunction

	localparam pow_tab_t POW_TAB_LO = gen_pow_tab(0);
	localparam pow_tab_t POW_TAB_HI = gen_pow_tab(CHUNK_W);

endpackage

@@ hdl/grim_pow3.sv @@
// 3^e mod 2^17: two table lookups, then one multiply
module grim_pow3 (
	input  logic                                clk,
	input  grim_pkg::pipe_ctrl_t                ctrl,
	input  logic [grim_pkg::EXP_W-1:0]          exponent,
	output grim_pkg::res_t                      pow_s2
);

	grim_pkg::res_t lo_s1;
	grim_pkg::res_t hi_s1;
	logic [2*grim_pkg::RES_W-1:0] prod;

	// stage 1: partial powers for the low and high exponent bytes
	always_ff @(posedge clk) begin
		if (ctrl.en_s1) begin
			lo_s1 <= grim_pkg::POW_TAB_LO[exponent[grim_pkg::CHUNK_W-1:0]];
			hi_s1 <= grim_pkg::POW_TAB_HI[exponent[grim_pkg::EXP_W-1:grim_pkg::CHUNK_W]];
		end
	end

	assign prod = (2*grim_pkg::RES_W)'(lo_s1) * (2*grim_pkg::RES_W)'(hi_s1);

	// stage 2: combine, keep the residue
	always_ff @(posedge clk) begin
		if (ctrl.en_s2) begin
			pow_s2 <= prod[grim_pkg::RES_W-1:0];
		end
	end

endmodule

@@ hdl/grim_addr_gen.sv @@
// final stage: residue to bit-reversed slot and its mirror
module grim_addr_gen #(
	parameter int unsigned POS_W = grim_pkg::MAX_LOG_LEN_DEF
) (
	input  logic                        clk,
	input  grim_pkg::pipe_ctrl_t        ctrl,
	input  logic [grim_pkg::LOG_W-1:0]  eff_len,
	input  grim_pkg::res_t              r_s3,
	input  grim_pkg::res_t              rn_s3,
	output logic [POS_W-1:0]            from_s4,
	output logic [POS_W-1:0]            to_s4,
	output logic [POS_W-1:0]            mfrom_s4,
	output logic [POS_W-1:0]            mto_s4
);

	logic [POS_W-1:0]           len_mask;
	logic [grim_pkg::LOG_W-1:0] rev_shift;
	logic [POS_W-1:0]           from_idx;
	logic [POS_W-1:0]           to_idx;
	logic [POS_W-1:0]           from_pos;
	logic [POS_W-1:0]           to_pos;

	function automatic logic [POS_W-1:0] rev_bits(input logic [POS_W-1:0] v);
		logic [POS_W-1:0] r;
		for (int unsigned k = 0; k < POS_W; k++) begin
			r[k] = v[POS_W-1-k];
		end
		return r;
	endfunction

	// residue is odd: (r-1)/2 is r shifted down, masked to log_len bits
	assign len_mask  = ~({POS_W{1'b1}} << eff_len);
	assign rev_shift = grim_pkg::LOG_W'(POS_W) - eff_len;
	assign from_idx  = r_s3[POS_W:1] & len_mask;
	assign to_idx    = rn_s3[POS_W:1] & len_mask;

	// reverse over the full width, then align to log_len bits
	assign from_pos = rev_bits(from_idx) >> rev_shift;
	assign to_pos   = rev_bits(to_idx) >> rev_shift;

	// len-1-x equals the complement within log_len bits
	always_ff @(posedge clk) begin
		if (ctrl.en_s4) begin
			from_s4  <= from_pos;
			to_s4    <= to_pos;
			mfrom_s4 <= ~from_pos & len_mask;
			mto_s4   <= ~to_pos & len_mask;
		end
	end

endmodule

@@ hdl/galois_rotation_index_map.sv @@
// Galois rotation address generator, four register stages.
// Pipeline: four stages (table, multiply, multiply, bit reverse); an accepted item's valid
// bit moves through valid_s1, valid_s2, valid_s3 and valid_s4, which drives out_valid.
// Throughput: one item per cycle while in_stall is low; each stage holds under out_stall without loss.
// Reset (arst_n low): all stage valid bits clear, log_len returns to MAX_LOG_LEN.
// A log_len of 0 acts as 1, a value above MAX_LOG_LEN acts as MAX_LOG_LEN.
module galois_rotation_index_map #(
	parameter int unsigned MAX_LOG_LEN = grim_pkg::MAX_LOG_LEN_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [grim_pkg::LOG_W-1:0]         cfg_wr_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [MAX_LOG_LEN-2:0]             pair_index,
	input  logic [grim_pkg::STEP_W-1:0]        rotation_step,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [MAX_LOG_LEN-1:0]             src_slot,
	output logic [MAX_LOG_LEN-1:0]             dst_slot,
	output logic [MAX_LOG_LEN-1:0]             mirror_from,
	output logic [MAX_LOG_LEN-1:0]             mirror_to
);

	localparam int unsigned POS_W  = MAX_LOG_LEN;
	localparam int unsigned PIDX_W = MAX_LOG_LEN - 1;

	logic [grim_pkg::LOG_W-1:0] eff_len_q;
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ready_s1, ready_s2, ready_s3, ready_s4;
	grim_pkg::pipe_ctrl_t ctrl;

	logic [grim_pkg::EXP_W-1:0] exp_i;
	logic [grim_pkg::EXP_W-1:0] exp_s;
	grim_pkg::res_t r_s2, f_s2;
	grim_pkg::res_t r_s3, rn_s3;
	logic [2*grim_pkg::RES_W-1:0] rf_prod;

	// length register, saturated on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_len_q <= grim_pkg::LOG_W'(MAX_LOG_LEN);
		end else if (cfg_wr_en) begin
			if (cfg_wr_data == '0) begin
				eff_len_q <= grim_pkg::LOG_W'(1);
			end else if (cfg_wr_data > grim_pkg::LOG_W'(MAX_LOG_LEN)) begin
				eff_len_q <= grim_pkg::LOG_W'(MAX_LOG_LEN);
			end else begin
				eff_len_q <= cfg_wr_data;
			end
		end
	end

	// stall chain: a stage loads when it is empty or its content moves on
	assign ready_s4 = !valid_s4 || !out_stall;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_stall = !ready_s1;

	assign ctrl.en_s1 = ready_s1 && in_valid;
	assign ctrl.en_s2 = ready_s2 && valid_s1;
	assign ctrl.en_s3 = ready_s3 && valid_s2;
	assign ctrl.en_s4 = ready_s4 && valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	// exponents; step bits above the order of 3 do not matter
	assign exp_i = {{(grim_pkg::EXP_W-PIDX_W){1'b0}}, pair_index};
	assign exp_s = rotation_step[grim_pkg::EXP_W-1:0];

	grim_pow3 u_pow_i (
		.clk      (clk),
		.ctrl     (ctrl),
		.exponent (exp_i),
		.pow_s2   (r_s2)
	);

	grim_pow3 u_pow_s (
		.clk      (clk),
		.ctrl     (ctrl),
		.exponent (exp_s),
		.pow_s2   (f_s2)
	);

	assign rf_prod = (2*grim_pkg::RES_W)'(r_s2) * (2*grim_pkg::RES_W)'(f_s2);

	// stage 3: rotated residue r*f
	always_ff @(posedge clk) begin
		if (ctrl.en_s3) begin
			r_s3  <= r_s2;
			rn_s3 <= rf_prod[grim_pkg::RES_W-1:0];
		end
	end

	grim_addr_gen #(
		.POS_W (POS_W)
	) u_addr (
		.clk      (clk),
		.ctrl     (ctrl),
		.eff_len  (eff_len_q),
		.r_s3     (r_s3),
		.rn_s3    (rn_s3),
		.from_s4  (src_slot),
		.to_s4    (dst_slot),
		.mfrom_s4 (mirror_from),
		.mto_s4   (mirror_to)
	);

	assign out_valid = valid_s4;

endmodule

@@ tb/galois_rotation_index_map_tb.sv @@
`timescale 1ns / 1ps

module galois_rotation_index_map_tb;

	localparam int unsigned LEN_MAX     = grim_pkg::MAX_LOG_LEN_DEF;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned PHASES      = 9;
	localparam int unsigned PHASE_ITEMS = 72;
	localparam int unsigned DIR_COUNT   = 21;

	// one set of slot addresses
	typedef struct packed {
		logic [LEN_MAX-1:0] from_pos;
		logic [LEN_MAX-1:0] to_pos;
		logic [LEN_MAX-1:0] mirror_from;
		logic [LEN_MAX-1:0] mirror_to;
	} slot_set_t;

	// directed row: length setting, item, and a typed expectation when fixed
	typedef struct packed {
		logic [grim_pkg::LOG_W-1:0]  len_sel;
		logic [LEN_MAX-2:0]          idx;
		logic [grim_pkg::STEP_W-1:0] step;
		logic                        typed;
		slot_set_t                   slots;
	} dir_row_t;

	localparam slot_set_t NO_SLOTS = '{16'd0, 16'd0, 16'd0, 16'd0};

	localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
		'{5'd16, 15'd0,     17'd0,      1'b1, '{16'd0, 16'd0, 16'd65535, 16'd65535}},
		'{5'd16, 15'd1,     17'd0,      1'b1, '{16'd32768, 16'd32768, 16'd32767, 16'd32767}},
		'{5'd16, 15'd0,     17'd1,      1'b1, '{16'd0, 16'd32768, 16'd65535, 16'd32767}},
		'{5'd16, 15'h7fff,  17'h1ffff,  1'b0, NO_SLOTS},
		'{5'd16, 15'h7fff,  17'd0,      1'b0, NO_SLOTS},
		'{5'd16, 15'd0,     17'h1ffff,  1'b0, NO_SLOTS},
		'{5'd16, 15'h4000,  17'h10000,  1'b0, NO_SLOTS},
		'{5'd16, 15'd12345, 17'd98765,  1'b0, NO_SLOTS},
		// register above the maximum saturates
		'{5'd31, 15'd0,     17'd0,      1'b1, '{16'd0, 16'd0, 16'd65535, 16'd65535}},
		'{5'd31, 15'h7fff,  17'h1ffff,  1'b0, NO_SLOTS},
		'{5'd17, 15'd5,     17'd7,      1'b0, NO_SLOTS},
		// shortest length
		'{5'd1,  15'd0,     17'd0,      1'b1, '{16'd0, 16'd0, 16'd1, 16'd1}},
		'{5'd1,  15'd1,     17'd0,      1'b1, '{16'd1, 16'd1, 16'd0, 16'd0}},
		// pair index far above half the length
		'{5'd1,  15'h7fff,  17'h1ffff,  1'b0, NO_SLOTS},
		// zero length setting acts as one
		'{5'd0,  15'd0,     17'd0,      1'b1, '{16'd0, 16'd0, 16'd1, 16'd1}},
		'{5'd0,  15'd1,     17'd1,      1'b0, NO_SLOTS},
		'{5'd2,  15'd3,     17'd5,      1'b0, NO_SLOTS},
		'{5'd8,  15'd127,   17'd200,    1'b0, NO_SLOTS},
		'{5'd8,  15'd300,   17'd1000,   1'b0, NO_SLOTS},
		'{5'd15, 15'd16383, 17'd65535,  1'b0, NO_SLOTS},
		'{5'd16, 15'd1,     17'd1,      1'b0, NO_SLOTS}
	};

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_wr_en;
	logic [grim_pkg::LOG_W-1:0]  cfg_wr_data;
	logic                        in_valid;
	logic                        in_stall;
	logic [LEN_MAX-2:0]          pair_index;
	logic [grim_pkg::STEP_W-1:0] rotation_step;
	logic                        out_valid;
	logic                        out_stall;
	logic [LEN_MAX-1:0]          src_slot;
	logic [LEN_MAX-1:0]          dst_slot;
	logic [LEN_MAX-1:0]          mirror_from;
	logic [LEN_MAX-1:0]          mirror_to;

	slot_set_t                  pending_slots[$];
	logic [grim_pkg::LOG_W-1:0] log_len_cfg;
	int unsigned                fail_count;
	int unsigned                cycle_count;
	int unsigned                next_gap;
	bit                         valid_held;
	bit                         send_burst;
	bit                         recv_burst;

	galois_rotation_index_map u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.pair_index    (pair_index),
		.rotation_step (rotation_step),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.src_slot      (src_slot),
		.dst_slot      (dst_slot),
		.mirror_from   (mirror_from),
		.mirror_to     (mirror_to)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// length setting clamped to 1..LEN_MAX
	function automatic int unsigned eff_len_bits(input logic [grim_pkg::LOG_W-1:0] sel);
		int unsigned l;
		l = sel;
		if (l < 1) l = 1;
		if (l > LEN_MAX) l = LEN_MAX;
		return l;
	endfunction

	// 3^e modulo mask+1
	function automatic int unsigned gal_pow3(input int unsigned e, input int unsigned mask);
		longint unsigned acc;
		longint unsigned base;
		acc  = 1;
		base = 3 & mask;
		for (int b = 0; b < grim_pkg::STEP_W; b++) begin
			if (((e >> b) & 1) != 0) acc = (acc * base) & mask;
			base = (base * base) & mask;
		end
		return int'(acc & mask);
	endfunction

	function automatic int unsigned slot_bitrev(input int unsigned v, input int unsigned bits);
		int unsigned r;
		r = 0;
		for (int k = 0; k < bits; k++) begin
			r = (r << 1) | ((v >> k) & 1);
		end
		return r;
	endfunction

	// source, destination and mirrored slots for one pair index and step
	function automatic slot_set_t predict_slots(input logic [grim_pkg::LOG_W-1:0] sel,
			input logic [LEN_MAX-2:0] idx, input logic [grim_pkg::STEP_W-1:0] step);
		int unsigned     l;
		int unsigned     len;
		int unsigned     mask;
		int unsigned     r;
		int unsigned     f;
		int unsigned     rn;
		int unsigned     src;
		int unsigned     dst;
		slot_set_t       res;
		l    = eff_len_bits(sel);
		len  = 1 << l;
		mask = (1 << (l + 1)) - 1;
		r    = gal_pow3(idx, mask);
		f    = gal_pow3(step, mask);
		rn   = int'((longint'(r) * longint'(f)) & mask);
		src  = slot_bitrev((r - 1) >> 1, l);
		dst  = slot_bitrev((rn - 1) >> 1, l);
		res.from_pos    = LEN_MAX'(src);
		res.to_pos      = LEN_MAX'(dst);
		res.mirror_from = LEN_MAX'(len - 1 - src);
		res.mirror_to   = LEN_MAX'(len - 1 - dst);
		return res;
	endfunction

	// present one item, record its slots at acceptance, draw the gap to the next
	task automatic send_item(input logic [LEN_MAX-2:0] idx,
			input logic [grim_pkg::STEP_W-1:0] step, input slot_set_t slots);
		bit taken;
		repeat (next_gap) @(posedge clk);
		in_valid      <= 1'b1;
		pair_index    <= idx;
		rotation_step <= step;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = in_valid && !in_stall;
		end
		pending_slots.push_back(slots);
		next_gap = send_burst ? 0 : $urandom_range(0, 9);
		if (next_gap == 0) begin
			valid_held = 1'b1;
		end else begin
			in_valid   <= 1'b0;
			valid_held = 1'b0;
		end
	endtask

	task automatic idle_sender();
		if (valid_held) begin
			in_valid   <= 1'b0;
			valid_held = 1'b0;
		end
	endtask

	task automatic wait_drained();
		while (pending_slots.size() != 0) @(posedge clk);
	endtask

	// only written with the block empty
	task automatic set_log_len(input logic [grim_pkg::LOG_W-1:0] sel);
		idle_sender();
		wait_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= sel;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		log_len_cfg = sel;
	endtask

	task automatic send_random(input int unsigned count);
		int unsigned                 half;
		logic [LEN_MAX-2:0]          idx;
		logic [grim_pkg::STEP_W-1:0] step;
		half = 1 << (eff_len_bits(log_len_cfg) - 1);
		for (int n = 0; n < count; n++) begin
			// mostly legal pair indices, some anywhere in the field
			if ($urandom_range(0, 4) != 0) idx = (LEN_MAX-1)'($urandom_range(0, half - 1));
			else idx = (LEN_MAX-1)'($urandom);
			if ($urandom_range(0, 7) == 0) step = grim_pkg::STEP_W'($urandom_range(0, 3));
			else step = grim_pkg::STEP_W'($urandom);
			send_item(idx, step, predict_slots(log_len_cfg, idx, step));
			// in about half the runs, one full stop of the sender mid-run
			if (n == count / 2 && $urandom_range(0, 1) == 0) begin
				idle_sender();
				wait_drained();
			end
		end
	endtask

	// result side: random stall ahead of every item unless in burst mode, then compare
	initial begin
		slot_set_t want;
		int unsigned stall_len;
		@(posedge arst_n);
		forever begin
			stall_len = recv_burst ? 0 : $urandom_range(0, 9);
			if (stall_len > 0) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			if (pending_slots.size() == 0) begin
				$error("unexpected item: src_slot %0d dst_slot %0d", src_slot, dst_slot);
				fail_count++;
			end else begin
				want = pending_slots.pop_front();
				if (src_slot !== want.from_pos) begin
					$error("src_slot: expected %0d, actual %0d", want.from_pos, src_slot);
					fail_count++;
				end
				if (dst_slot !== want.to_pos) begin
					$error("dst_slot: expected %0d, actual %0d", want.to_pos, dst_slot);
					fail_count++;
				end
				if (mirror_from !== want.mirror_from) begin
					$error("mirror_from: expected %0d, actual %0d", want.mirror_from,
						mirror_from);
					fail_count++;
				end
				if (mirror_to !== want.mirror_to) begin
					$error("mirror_to: expected %0d, actual %0d", want.mirror_to, mirror_to);
					fail_count++;
				end
			end
		end
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// reset, directed table, random phases, drain
	initial begin
		logic [grim_pkg::LOG_W-1:0] phase_len [PHASES];
		phase_len = '{5'd16, 5'd1, 5'd31, 5'd9, 5'd0, 5'd14, 5'd2, 5'd16, 5'd16};
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		in_valid      = 1'b0;
		pair_index    = '0;
		rotation_step = '0;
		out_stall     = 1'b0;
		log_len_cfg   = 5'd16;
		fail_count    = 0;
		next_gap      = 0;
		valid_held    = 1'b0;
		send_burst    = 1'b0;
		recv_burst    = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < DIR_COUNT; k++) begin
			if (DIR_ROWS[k].len_sel != log_len_cfg) set_log_len(DIR_ROWS[k].len_sel);
			if (DIR_ROWS[k].typed)
				send_item(DIR_ROWS[k].idx, DIR_ROWS[k].step, DIR_ROWS[k].slots);
			else
				send_item(DIR_ROWS[k].idx, DIR_ROWS[k].step,
					predict_slots(log_len_cfg, DIR_ROWS[k].idx, DIR_ROWS[k].step));
		end

		// last phase takes a random setting
		phase_len[PHASES-1] = grim_pkg::LOG_W'($urandom_range(0, 31));
		for (int p = 0; p < PHASES; p++) begin
			set_log_len(phase_len[p]);
			send_burst = (p % 3 == 1) || ($urandom_range(0, 3) == 0);
			recv_burst = (p % 3 == 2) || ($urandom_range(0, 3) == 0);
			send_random(PHASE_ITEMS);
		end

		idle_sender();
		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
